FILE: hdl/vhmt_pkg.sv
// Package for the voice histogram max tracker.
// Holds sizes, operation codes, sequencer states and the structs passed between modules.
// No dependencies.
`default_nettype none

package vhmt_pkg;

	localparam int NUM_VOICES = 512;
	localparam int COUNT_BITS = 16;
	localparam int VOICE_W    = $clog2(NUM_VOICES);
	localparam int ACTIVE_W   = $clog2(NUM_VOICES + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_COUNT     = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_GET       = 2'd2,
		OP_CLEAR_ALL = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_LEAD,
		S_HIST,
		S_CUR,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		UOP_INC_SAT,
		UOP_CMP_GE,
		UOP_CMP_GT
	} uop_t;

	typedef struct packed {
		uop_t                  op;
		logic [COUNT_BITS-1:0] a;
		logic [COUNT_BITS-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] res;
		logic                  flag;
	} unit_rsp_t;

	typedef struct packed {
		logic [VOICE_W-1:0]    cnt_addr;
		logic                  cnt_we;
		logic [COUNT_BITS-1:0] cnt_wd;
		logic [VOICE_W-1:0]    hist_addr;
		logic                  hist_we;
		logic [VOICE_W-1:0]    hist_wd;
	} tbl_req_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt_rd;
		logic [VOICE_W-1:0]    hist_rd;
	} tbl_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/vhmt_if.sv
// Channel interfaces for the voice histogram max tracker.
// Depends on vhmt_pkg for field widths.
`default_nettype none

interface vhmt_in_if import vhmt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [VOICE_W-1:0] voice;

	modport source (output valid, output opcode, output voice, input ready);
	modport sink (input valid, input opcode, input voice, output ready);
endinterface

interface vhmt_out_if import vhmt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VOICE_W-1:0]    voice_out;
	logic [COUNT_BITS-1:0] count_out;
	logic [ACTIVE_W-1:0]   active_voices;
	logic [VOICE_W-1:0]    leader_voice;
	logic [COUNT_BITS-1:0] leader_count;
	logic [VOICE_W-1:0]    peak_voice;
	logic                  leader_changed;
	logic                  found;

	modport source (
		output valid, output voice_out, output count_out, output active_voices,
		output leader_voice, output leader_count, output peak_voice,
		output leader_changed, output found, input ready
	);
	modport sink (
		input valid, input voice_out, input count_out, input active_voices,
		input leader_voice, input leader_count, input peak_voice,
		input leader_changed, input found, output ready
	);
endinterface

`default_nettype wire

FILE: hdl/voice_histogram_max_tracker.sv
// Top level of the voice histogram max tracker: sequencer, state registers and output register.
// Depends on vhmt_pkg, vhmt_if, vhmt_unit and vhmt_tables.
//
//   Channel  Direction  Handshake      Payload
//   req      in         valid/ready    opcode, voice
//   rsp      out        valid/ready    voice_out .. found (one register stage)
//   cfg      in         cfg_we         cfg_wdata (strict mode)
//
// Count: read, lead, emit. Clear: read, then hist and cur if it hits and history is left, then emit.
// Get: read, then emit, or back to idle without a transaction if there is nothing to report. Clear all
// and reset walk all NUM_VOICES (512) entries of both tables with req.ready low.
// A stalled rsp holds its register; the next request is accepted meanwhile and waits at emit.
`default_nettype none

module voice_histogram_max_tracker import vhmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	vhmt_in_if.sink    req,
	vhmt_out_if.source rsp
);

	state_t                state_q, state_d;
	logic                  strict_q;
	logic [ACTIVE_W-1:0]   active_q;
	logic [COUNT_BITS-1:0] lead_cnt_q;
	logic [VOICE_W-1:0]    lead_v_q;
	logic [VOICE_W-1:0]    pos_q;
	logic [ACTIVE_W-1:0]   fill_q;
	logic [VOICE_W-1:0]    top_q;
	logic [VOICE_W-1:0]    sweep_q;
	logic                  post_q;
	logic                  out_valid_q;

	op_t                   op_q;
	logic [VOICE_W-1:0]    voice_q;
	logic [COUNT_BITS-1:0] c_q;
	logic [VOICE_W-1:0]    slot_q;
	logic [VOICE_W-1:0]    prev_q;
	logic [COUNT_BITS-1:0] res_cnt_q;
	logic                  changed_q;
	logic                  found_q;

	logic [VOICE_W-1:0]    o_voice_q;
	logic [COUNT_BITS-1:0] o_count_q;
	logic [ACTIVE_W-1:0]   o_active_q;
	logic [VOICE_W-1:0]    o_lead_v_q;
	logic [COUNT_BITS-1:0] o_lead_cnt_q;
	logic [VOICE_W-1:0]    o_top_q;
	logic                  o_changed_q;
	logic                  o_found_q;

	unit_req_t          ureq;
	unit_rsp_t          ursp;
	tbl_req_t           treq;
	tbl_rsp_t           trsp;
	logic               accept;
	logic               emit_load;
	logic               sweep_last;
	logic               clr_hit;
	logic [VOICE_W-1:0] pos_inc;
	logic [VOICE_W-1:0] slot;

	vhmt_unit u_unit (
		.req (ureq),
		.rsp (ursp)
	);

	vhmt_tables u_tables (
		.clk (clk),
		.req (treq),
		.rsp (trsp)
	);

	assign accept     = req.valid && req.ready;
	assign emit_load  = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);
	assign sweep_last = (sweep_q == VOICE_W'(NUM_VOICES - 1));
	assign clr_hit    = (trsp.cnt_rd != '0) && (active_q != '0);
	assign pos_inc    = (pos_q == VOICE_W'(NUM_VOICES - 1)) ? '0 : pos_q + 1'b1;
	assign slot       = (pos_q == '0) ? VOICE_W'(NUM_VOICES - 1) : pos_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req.ready      = 1'b0;
		treq           = '0;
		treq.cnt_addr  = voice_q;
		ureq.op        = UOP_INC_SAT;
		ureq.a         = trsp.cnt_rd;
		ureq.b         = lead_cnt_q;
		unique case (state_q)
			S_CLEAR: begin
				treq.cnt_addr  = sweep_q;
				treq.cnt_we    = 1'b1;
				treq.hist_addr = sweep_q;
				treq.hist_we   = 1'b1;
				if (sweep_last) begin
					state_d = post_q ? S_EMIT : S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready     = 1'b1;
				treq.cnt_addr = req.voice;
				if (accept) begin
					state_d = (op_t'(req.opcode) == OP_CLEAR_ALL) ? S_CLEAR : S_READ;
				end
			end
			S_READ: begin
				unique case (op_q)
					OP_COUNT: begin
						treq.cnt_we = 1'b1;
						treq.cnt_wd = ursp.res;
						state_d     = S_LEAD;
					end
					OP_CLEAR: begin
						state_d = S_EMIT;
						if (clr_hit) begin
							treq.cnt_we = 1'b1;
							if (fill_q != '0) begin
								treq.hist_addr = slot;
								state_d        = S_HIST;
							end
						end
					end
					OP_GET: begin
						state_d = (clr_hit) ? S_EMIT : S_IDLE;
					end
					OP_CLEAR_ALL: begin
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_LEAD: begin
				ureq.op = strict_q ? UOP_CMP_GT : UOP_CMP_GE;
				ureq.a  = c_q;
				if (ursp.flag && (voice_q != lead_v_q)) begin
					treq.hist_addr = pos_inc;
					treq.hist_we   = 1'b1;
					treq.hist_wd   = voice_q;
				end
				state_d = S_EMIT;
			end
			S_HIST: begin
				treq.cnt_addr = trsp.hist_rd;
				state_d       = S_CUR;
			end
			S_CUR: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q    <= 1'b0;
			active_q    <= '0;
			lead_cnt_q  <= '0;
			lead_v_q    <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			top_q       <= '0;
			sweep_q     <= '0;
			post_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				strict_q <= cfg_wdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
					if (sweep_last) begin
						post_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept && (op_t'(req.opcode) == OP_CLEAR_ALL)) begin
						active_q   <= '0;
						lead_cnt_q <= '0;
						lead_v_q   <= '0;
						pos_q      <= '0;
						fill_q     <= '0;
						top_q      <= '0;
						sweep_q    <= '0;
						post_q     <= 1'b1;
					end
				end
				S_READ: begin
					if (op_q == OP_COUNT) begin
						if (ursp.flag) begin
							active_q <= active_q + 1'b1;
						end
					end else if ((op_q == OP_CLEAR) && clr_hit) begin
						active_q <= active_q - 1'b1;
						if (fill_q != '0) begin
							fill_q <= fill_q - 1'b1;
						end else begin
							lead_cnt_q <= '0;
							lead_v_q   <= '0;
							pos_q      <= '0;
						end
					end
				end
				S_LEAD: begin
					if (ursp.flag) begin
						if (voice_q != lead_v_q) begin
							if (fill_q < ACTIVE_W'(NUM_VOICES)) begin
								fill_q <= fill_q + 1'b1;
							end
							pos_q    <= pos_inc;
							lead_v_q <= voice_q;
						end
						lead_cnt_q <= c_q;
					end
					if (voice_q > top_q) begin
						top_q <= voice_q;
					end
				end
				S_CUR: begin
					if ((fill_q == '0) || (trsp.cnt_rd == '0)) begin
						lead_cnt_q <= '0;
						lead_v_q   <= '0;
						pos_q      <= '0;
					end else begin
						lead_cnt_q <= trsp.cnt_rd;
						lead_v_q   <= prev_q;
						pos_q      <= slot_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= op_t'(req.opcode);
					voice_q   <= req.voice;
					res_cnt_q <= '0;
					changed_q <= 1'b0;
					found_q   <= 1'b0;
				end
			end
			S_READ: begin
				unique case (op_q)
					OP_COUNT: begin
						c_q <= ursp.res;
					end
					OP_CLEAR: begin
						slot_q    <= slot;
						res_cnt_q <= (clr_hit && (fill_q == '0)) ? '0 : lead_cnt_q;
					end
					OP_GET: begin
						res_cnt_q <= trsp.cnt_rd;
						found_q   <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_LEAD: begin
				res_cnt_q <= c_q;
				changed_q <= ursp.flag;
			end
			S_HIST: begin
				prev_q <= trsp.hist_rd;
			end
			S_CUR: begin
				res_cnt_q <= (fill_q == '0) ? '0 : trsp.cnt_rd;
			end
			default: begin
			end
		endcase
		if (emit_load) begin
			o_voice_q    <= voice_q;
			o_count_q    <= res_cnt_q;
			o_active_q   <= active_q;
			o_lead_v_q   <= lead_v_q;
			o_lead_cnt_q <= lead_cnt_q;
			o_top_q      <= top_q;
			o_changed_q  <= changed_q;
			o_found_q    <= found_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.voice_out      = o_voice_q;
	assign rsp.count_out      = o_count_q;
	assign rsp.active_voices  = o_active_q;
	assign rsp.leader_voice   = o_lead_v_q;
	assign rsp.leader_count   = o_lead_cnt_q;
	assign rsp.peak_voice     = o_top_q;
	assign rsp.leader_changed = o_changed_q;
	assign rsp.found          = o_found_q;

	// The block works on one transaction at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while a transaction was in progress");

	// The number of active voices never exceeds the table size.
	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= ACTIVE_W'(NUM_VOICES))
		else $error("active voice count out of range");

	// A leader with zero count is always the reset leader.
	a_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(lead_cnt_q == '0) |-> (lead_v_q == '0))
		else $error("leader voice set with zero count");

	// A get report never flags a change of leader.
	a_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> !rsp.leader_changed)
		else $error("get report flagged a leader change");

endmodule

`default_nettype wire

FILE: hdl/vhmt_unit.sv
// Shared count unit: saturating increment and leader compare.
// Depends on vhmt_pkg for the request and response structs.
`default_nettype none

module vhmt_unit import vhmt_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	always_comb begin
		rsp.res  = req.a;
		rsp.flag = 1'b0;
		unique case (req.op)
			UOP_INC_SAT: begin
				rsp.res  = (req.a == COUNT_MAX) ? req.a : req.a + 1'b1;
				rsp.flag = (req.a == '0);
			end
			UOP_CMP_GE: begin
				rsp.flag = (req.a >= req.b);
			end
			UOP_CMP_GT: begin
				rsp.flag = (req.a > req.b);
			end
			default: begin
				rsp.flag = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/vhmt_tables.sv
// Count table and leader history ring, each a single-port memory with registered read.
// Depends on vhmt_pkg for the table request and response structs.
`default_nettype none

module vhmt_tables import vhmt_pkg::*; (
	input  logic     clk,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	logic [COUNT_BITS-1:0] count_mem [NUM_VOICES];
	logic [VOICE_W-1:0]    hist_mem [NUM_VOICES];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [VOICE_W-1:0]    hist_rd_q;

	always_ff @(posedge clk) begin
		if (req.cnt_we) begin
			count_mem[req.cnt_addr] <= req.cnt_wd;
		end
		cnt_rd_q <= count_mem[req.cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (req.hist_we) begin
			hist_mem[req.hist_addr] <= req.hist_wd;
		end
		hist_rd_q <= hist_mem[req.hist_addr];
	end

	assign rsp.cnt_rd  = cnt_rd_q;
	assign rsp.hist_rd = hist_rd_q;

endmodule

`default_nettype wire
